>>> rtl/histogram_l2_chi_square_likelihood_core_defines.svh
// Assertion macros for the histogram chi-square likelihood core.
// Needs a clk and an active-high rst in the scope that uses them.
`ifndef HISTOGRAM_L2_CHI_SQUARE_LIKELIHOOD_CORE_DEFINES_SVH
`define HISTOGRAM_L2_CHI_SQUARE_LIKELIHOOD_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hcsl_pkg.sv
// Package for the histogram chi-square likelihood core: states, widths,
// register indexes and the exponent factor table. No dependencies.
package hcsl_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 12;
  localparam int ACC_WIDTH    = 48;
  localparam int SCORE_WIDTH  = 32;
  localparam int DIVD_WIDTH   = 2 * SAMPLE_WIDTH + FRAC_BITS;
  localparam int DEN_WIDTH    = SAMPLE_WIDTH + 1;
  localparam int ROOT_WIDTH   = ACC_WIDTH / 2;
  localparam int PROD_WIDTH   = ACC_WIDTH + ROOT_WIDTH;
  localparam int N_FACTORS    = 20;
  localparam int DIV_CYCLES   = DIVD_WIDTH / 2;
  localparam int STEP_WIDTH   = 5;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_SCORE_GAIN   = 1'b0;
  localparam logic REG_BLOCK_LENGTH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_L2, ST_DIV, ST_CHI, ST_SQRT, ST_PROD, ST_SCORE,
    ST_GAIN, ST_EXP, ST_DONE
  } state_t;

  typedef logic [30:0] factor_t;
  typedef factor_t factor_tab_t [N_FACTORS];

  localparam factor_t Q30_ONE = 31'h4000_0000;

  // Restoring shift-and-subtract quotient, used only for the table.
  function automatic logic [63:0] div_const(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [64:0] rm;
    q  = 64'd0;
    rm = 65'd0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[63:0], a[i]};
      if (rm >= {1'b0, b}) begin
        rm   = rm - {1'b0, b};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-2^-k) in Q.30 from an alternating series kept in Q.60.
  function automatic logic [63:0] exp_series(input int unsigned k);
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] n;
    term = 64'd1 << 60;
    pos  = 64'd1 << 60;
    neg  = 64'd0;
    for (int i = 1; i < 40; i++) begin
      if (term != 64'd0) begin
        n    = 64'(i);
        term = div_const(term >> k, n);
        if (n[0]) neg = neg + term;
        else pos = pos + term;
      end
    end
    return ((pos - neg) + (64'd1 << 29)) >> 30;
  endfunction

  // Rounded Q.30 product, used only for the table.
  function automatic logic [63:0] mul_q30_const(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Factor i multiplies in when bit 35-i of the scaled exponent is set.
  function automatic factor_tab_t build_factors();
    factor_tab_t t;
    logic [63:0] f3;
    logic [63:0] f2;
    logic [63:0] f1;
    f3 = exp_series(0);
    f2 = mul_q30_const(f3, f3);
    f1 = mul_q30_const(f2, f2);
    t[3] = factor_t'(f3);
    t[2] = factor_t'(f2);
    t[1] = factor_t'(f1);
    t[0] = factor_t'(mul_q30_const(f1, f1));
    for (int i = 4; i < N_FACTORS; i++) begin
      t[i] = factor_t'(exp_series(i - 3));
    end
    return t;
  endfunction

  localparam factor_tab_t FACTORS = build_factors();

endpackage

>>> rtl/histogram_l2_chi_square_likelihood_core.sv
// Histogram L2 / chi-square distance likelihood core, top level.
// Depends on hcsl_pkg and histogram_l2_chi_square_likelihood_core_defines.svh.
//
// Usage: each input item carries one measured and one predicted histogram bin
// (unsigned Q4.12) and a last_element mark. Items move on valid/ready.
// The block works on one item at a time and raises in_ready only when idle.
// An ordinary bin keeps in_ready low after acceptance through a squaring step,
// an accumulate step, a radix-2 restoring divider that retires two quotient
// bits per cycle and a chi update step, so the block takes a new item only
// once it is through with the last one.
// A bin that closes a block adds a bit-pair square root, a shift-add
// multiplier and a score update.
// A last bin adds the gain multiply and 20 serial Q.30 multiplies for the
// exponent, then the load of the output register.
// Only the last bin of a particle produces an output item (weight, score,
// score_saturated); it sits in an output register until out_ready, so the
// block goes on with the next particle while the result waits. If a second
// result is ready before the first is taken, the block holds in its final
// state until the output register is free. Reset (rst, synchronous) clears
// all accumulators and sets score_gain to 1.0 and block_length to 32. The user
// must write the APB-style configuration port only while idle (unenforced).
`include "histogram_l2_chi_square_likelihood_core_defines.svh"

module histogram_l2_chi_square_likelihood_core #(
  parameter int MAX_BLOCK_LENGTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [hcsl_pkg::SAMPLE_WIDTH-1:0] measured_value,
  input  logic [hcsl_pkg::SAMPLE_WIDTH-1:0] predicted_value,
  input  logic                              last_element,
  // Output channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       weight,
  output logic [31:0]                       score,
  output logic                              score_saturated
);
  import hcsl_pkg::*;

  localparam int CW = (MAX_BLOCK_LENGTH > 2) ? $clog2(MAX_BLOCK_LENGTH) : 1;
  localparam logic [47:0] ACC_MAX = {ACC_WIDTH{1'b1}};

  // Configuration registers.
  logic [31:0] score_gain;
  logic [10:0] block_length;

  // Control.
  state_t state, state_next;
  logic [STEP_WIDTH-1:0] step;
  logic cfg_write;
  logic in_accept;
  logic out_load;

  // Item and running state.
  logic [SAMPLE_WIDTH-1:0] meas;
  logic [SAMPLE_WIDTH-1:0] pred;
  logic                    last_r;
  logic [2*SAMPLE_WIDTH-1:0] sq;
  logic [DEN_WIDTH-1:0]    den;
  logic [DIVD_WIDTH-1:0]   dq;
  logic [DEN_WIDTH-1:0]    rem;
  logic [ACC_WIDTH-1:0]    l2;
  logic [ACC_WIDTH-1:0]    chi;
  logic [SCORE_WIDTH-1:0]  score_acc;
  logic                    sat_flag;
  logic [CW-1:0]           bin_counter;
  logic [ACC_WIDTH-1:0]    sq_op;
  logic [ROOT_WIDTH-1:0]   root;
  logic [ROOT_WIDTH+1:0]   srem;
  logic [PROD_WIDTH-1:0]   pr;
  logic [N_FACTORS-1:0]    xbits;
  logic                    xbig;
  factor_t                 r;

  // Combinational helpers.
  logic [SAMPLE_WIDTH-1:0] diff;
  logic [DIVD_WIDTH-1:0]   dq_next;
  logic [DEN_WIDTH-1:0]    rem_next;
  logic [DEN_WIDTH:0]      rs;
  logic [ACC_WIDTH:0]      l2_sum;
  logic [ACC_WIDTH:0]      chi_sum;
  logic [31:0]             bl_eff;
  logic [31:0]             count;
  logic                    block_end;
  logic [ROOT_WIDTH+3:0]   sr;
  logic [ROOT_WIDTH+3:0]   trial;
  logic [ROOT_WIDTH-1:0]   root_next;
  logic [ROOT_WIDTH+1:0]   srem_next;
  logic [ACC_WIDTH:0]      pp_sum;
  logic [SCORE_WIDTH:0]    score_sum;
  logic                    score_ovf;
  logic [63:0]             x;
  logic [61:0]             rf;
  logic [62:0]             rf_round;
  logic [31:0]             w_round;

  // APB access: always ready, address bit 2 picks the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_SCORE_GAIN:   prdata = score_gain;
      REG_BLOCK_LENGTH: prdata = {21'b0, block_length};
      default:          prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_gain   <= 32'h0001_0000;
      block_length <= 11'd32;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SCORE_GAIN:   score_gain   <= pwdata;
        REG_BLOCK_LENGTH: block_length <= pwdata[10:0];
        default:          score_gain   <= score_gain;
      endcase
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  // Absolute difference of the pair.
  assign diff = (meas > pred) ? (meas - pred) : (pred - meas);

  // Two restoring division steps per cycle.
  always_comb begin
    dq_next  = dq;
    rem_next = rem;
    rs       = '0;
    for (int i = 0; i < 2; i++) begin
      rs      = {rem_next, dq_next[DIVD_WIDTH-1]};
      dq_next = {dq_next[DIVD_WIDTH-2:0], 1'b0};
      if (rs >= {1'b0, den}) begin
        rem_next   = DEN_WIDTH'(rs - {1'b0, den});
        dq_next[0] = 1'b1;
      end else begin
        rem_next = DEN_WIDTH'(rs);
      end
    end
  end

  // Saturating accumulator sums.
  assign l2_sum  = {1'b0, l2} + {17'b0, sq};
  assign chi_sum = {1'b0, chi} + {5'b0, dq};

  // Block length, clamped to 1..MAX_BLOCK_LENGTH.
  always_comb begin
    if (block_length == 11'd0) bl_eff = 32'd1;
    else if ({21'b0, block_length} > 32'(MAX_BLOCK_LENGTH)) bl_eff = 32'(MAX_BLOCK_LENGTH);
    else bl_eff = {21'b0, block_length};
  end
  assign count     = 32'(bin_counter) + 32'd1;
  assign block_end = (count >= bl_eff);

  // One bit pair of the integer square root.
  always_comb begin
    sr    = {srem, sq_op[ACC_WIDTH-1:ACC_WIDTH-2]};
    trial = {2'b0, root, 2'b01};
    if (sr >= trial) begin
      srem_next = (ROOT_WIDTH+2)'(sr - trial);
      root_next = {root[ROOT_WIDTH-2:0], 1'b1};
    end else begin
      srem_next = (ROOT_WIDTH+2)'(sr);
      root_next = {root[ROOT_WIDTH-2:0], 1'b0};
    end
  end

  // Shift-add product of root and chi sum, one root bit per cycle.
  assign pp_sum = {1'b0, pr[PROD_WIDTH-1:ROOT_WIDTH]} + (pr[0] ? {1'b0, chi} : '0);

  // Score update; any product bit at 2^52 or above saturates the score.
  assign score_sum = {1'b0, score_acc} + {1'b0, pr[51:20]};
  assign score_ovf = (|pr[PROD_WIDTH-1:52]) || score_sum[SCORE_WIDTH];

  // Exponent argument and the serial Q.30 product.
  assign x        = 64'(score_gain) * 64'(score_acc);
  assign rf       = 62'(r) * 62'(FACTORS[step]);
  assign rf_round = {1'b0, rf} + 63'(64'd1 << 29);
  assign w_round  = {1'b0, r} + 32'(1 << 13);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_accept) state_next = ST_SQ;
      ST_SQ:    state_next = ST_L2;
      ST_L2:    state_next = ST_DIV;
      ST_DIV:   if (step == STEP_WIDTH'(DIV_CYCLES - 1)) state_next = ST_CHI;
      ST_CHI: begin
        if (block_end) state_next = ST_SQRT;
        else if (last_r) state_next = ST_GAIN;
        else state_next = ST_IDLE;
      end
      ST_SQRT:  if (step == STEP_WIDTH'(ROOT_WIDTH - 1)) state_next = ST_PROD;
      ST_PROD:  if (step == STEP_WIDTH'(ROOT_WIDTH - 1)) state_next = ST_SCORE;
      ST_SCORE: state_next = last_r ? ST_GAIN : ST_IDLE;
      ST_GAIN:  state_next = ST_EXP;
      ST_EXP:   if (step == STEP_WIDTH'(N_FACTORS - 1)) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Running state and serial units.
  always_ff @(posedge clk) begin
    if (rst) begin
      l2          <= '0;
      chi         <= '0;
      score_acc   <= '0;
      sat_flag    <= 1'b0;
      bin_counter <= '0;
      step        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= '0;
        end
        ST_L2: begin
          if (l2_sum[ACC_WIDTH]) begin
            l2       <= ACC_MAX;
            sat_flag <= 1'b1;
          end else begin
            l2 <= l2_sum[ACC_WIDTH-1:0];
          end
          step <= '0;
        end
        ST_DIV: begin
          step <= (step == STEP_WIDTH'(DIV_CYCLES - 1)) ? '0 : step + 1'b1;
        end
        ST_CHI: begin
          // A zero denominator contributes nothing.
          if (den != '0) begin
            if (chi_sum[ACC_WIDTH]) begin
              chi      <= ACC_MAX;
              sat_flag <= 1'b1;
            end else begin
              chi <= chi_sum[ACC_WIDTH-1:0];
            end
          end
          bin_counter <= block_end ? '0 : CW'(count);
          step        <= '0;
        end
        ST_SQRT: begin
          step <= (step == STEP_WIDTH'(ROOT_WIDTH - 1)) ? '0 : step + 1'b1;
        end
        ST_PROD: begin
          step <= (step == STEP_WIDTH'(ROOT_WIDTH - 1)) ? '0 : step + 1'b1;
        end
        ST_SCORE: begin
          if (score_ovf) begin
            score_acc <= '1;
            sat_flag  <= 1'b1;
          end else begin
            score_acc <= score_sum[SCORE_WIDTH-1:0];
          end
          l2  <= '0;
          chi <= '0;
        end
        ST_GAIN: begin
          step <= '0;
        end
        ST_EXP: begin
          step <= (step == STEP_WIDTH'(N_FACTORS - 1)) ? '0 : step + 1'b1;
        end
        ST_DONE: begin
          // The particle is finished once its result is in the output register.
          if (out_load) begin
            l2          <= '0;
            chi         <= '0;
            score_acc   <= '0;
            sat_flag    <= 1'b0;
            bin_counter <= '0;
          end
        end
        default: step <= '0;
      endcase
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      meas   <= measured_value;
      pred   <= predicted_value;
      last_r <= last_element;
    end
    if (state == ST_SQ) begin
      sq  <= 32'(diff) * 32'(diff);
      den <= {1'b0, meas} + {1'b0, pred};
    end
    if (state == ST_L2) begin
      dq  <= {sq, {FRAC_BITS{1'b0}}};
      rem <= '0;
    end
    if (state == ST_DIV) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
    if (state == ST_CHI) begin
      sq_op <= l2;
      root  <= '0;
      srem  <= '0;
    end
    if (state == ST_SQRT) begin
      sq_op <= {sq_op[ACC_WIDTH-3:0], 2'b00};
      root  <= root_next;
      srem  <= srem_next;
      if (step == STEP_WIDTH'(ROOT_WIDTH - 1)) pr <= {{ACC_WIDTH{1'b0}}, root_next};
    end
    if (state == ST_PROD) begin
      pr <= {pp_sum, pr[ROOT_WIDTH-1:1]};
    end
    if (state == ST_GAIN) begin
      xbits <= x[35:16];
      xbig  <= |x[63:36];
      r     <= Q30_ONE;
    end
    if (state == ST_EXP) begin
      if (xbits[N_FACTORS-1]) r <= rf_round[60:30];
      xbits <= {xbits[N_FACTORS-2:0], 1'b0};
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (xbig) weight <= 16'd0;
      else if (w_round[30]) weight <= 16'hFFFF;
      else weight <= w_round[29:14];
      score           <= score_acc;
      score_saturated <= sat_flag;
    end
  end

  // Checks on the sequencer.
  `HCS_ASSERT_NEXT(a_accept_starts, in_accept, state == ST_SQ, "accepted item did not start")
  `HCS_ASSERT_NOW(a_div_step_range, state == ST_DIV, step < STEP_WIDTH'(DIV_CYCLES), "divider step out of range")
  `HCS_ASSERT_NEXT(a_done_loads_output, out_load, out_valid && state == ST_IDLE, "result not loaded")

endmodule

>>> bench/hcsl_likelihood_checker.sv
// Checker for the histogram chi-square likelihood core: watches the register
// port and both item channels, predicts each likelihood and compares it.
// Depends on hcsl_pkg for register indexes.
`timescale 1ns / 1ps

module hcsl_likelihood_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] measured_value,
  input  logic [15:0] predicted_value,
  input  logic        last_element,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] weight,
  input  logic [31:0] score,
  input  logic        score_saturated,
  output int          errors,
  output int          pending
);
  import hcsl_pkg::*;

  localparam logic [63:0] SUM_MAX   = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] TOTAL_MAX = 64'hFFFF_FFFF;
  localparam int          LEN_MAX   = 1024;

  typedef struct packed {
    logic [15:0] weight;
    logic [31:0] score;
    logic        saturated;
  } likelihood_t;

  likelihood_t likelihood_q[$];

  // Shadow registers and running distance state.
  logic [31:0] gain_reg;
  logic [10:0] blen_reg;
  int          bins_in_block;
  logic [63:0] l2_sum;
  logic [63:0] chi_sum;
  logic [63:0] total_dist;
  logic        sat_seen;
  logic [63:0] exp_tab [20];

  // exp(-2^-k) in Q.30, from a Q.60 alternating series.
  function automatic logic [63:0] exp_neg_pow2(int unsigned k);
    logic [63:0] t;
    logic [63:0] plus;
    logic [63:0] minus;
    t = 64'd1 << 60;
    plus = t;
    minus = 0;
    for (int n = 1; n < 40; n++) begin
      if (t != 0) begin
        t = (t >> k) / n;
        if (n % 2 == 1) minus += t;
        else plus += t;
      end
    end
    return ((plus - minus) + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] rmul30(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] likelihood_of(logic [31:0] g, logic [31:0] s);
    logic [63:0] x;
    logic [63:0] r;
    x = 64'(g) * 64'(s);
    r = 64'd1 << 30;
    if ((x >> 32) >= 16) return 16'd0;
    for (int i = 0; i < 20; i++) begin
      if (x[35 - i]) r = rmul30(r, exp_tab[i]);
    end
    r = (r + (64'd1 << 13)) >> 14;
    return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    if (b > SUM_MAX - a) begin
      sat_seen = 1'b1;
      return SUM_MAX;
    end
    return a + b;
  endfunction

  // Fold one bin into the running sums; push a likelihood on the last bin.
  task automatic fold_bin(logic [15:0] m, logic [15:0] p, logic last);
    logic [63:0]  d;
    logic [63:0]  sq;
    logic [63:0]  den;
    logic [63:0]  root;
    logic [127:0] prod;
    logic [63:0]  add;
    int           len;
    likelihood_t  e;
    d = (m > p) ? 64'(m - p) : 64'(p - m);
    sq = d * d;
    den = 64'(m) + 64'(p);
    l2_sum = sum_sat(l2_sum, sq);
    // A zero denominator adds nothing to the chi-square sum.
    if (den != 0)
      chi_sum = sum_sat(chi_sum, ((sq / den) << 12) + (((sq % den) << 12) / den));
    len = blen_reg;
    if (len < 1) len = 1;
    if (len > LEN_MAX) len = LEN_MAX;
    if (bins_in_block + 1 >= len) begin
      root = int_sqrt(l2_sum);
      prod = 128'(root) * 128'(chi_sum);
      add = (prod >> 64 != 0) ? TOTAL_MAX + 1 : 64'(prod >> 20);
      if (add > TOTAL_MAX - total_dist) begin
        total_dist = TOTAL_MAX;
        sat_seen = 1'b1;
      end else begin
        total_dist += add;
      end
      l2_sum = 0;
      chi_sum = 0;
      bins_in_block = 0;
    end else begin
      bins_in_block++;
    end
    if (last) begin
      e.weight = likelihood_of(gain_reg, total_dist[31:0]);
      e.score = total_dist[31:0];
      e.saturated = sat_seen;
      likelihood_q.push_back(e);
      bins_in_block = 0;
      l2_sum = 0;
      chi_sum = 0;
      total_dist = 0;
      sat_seen = 1'b0;
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    exp_tab[3] = exp_neg_pow2(0);
    exp_tab[2] = rmul30(exp_tab[3], exp_tab[3]);
    exp_tab[1] = rmul30(exp_tab[2], exp_tab[2]);
    exp_tab[0] = rmul30(exp_tab[1], exp_tab[1]);
    for (int i = 4; i < 20; i++) exp_tab[i] = exp_neg_pow2(i - 3);
  end

  // Results are checked before the item of the same edge is folded in.
  always @(posedge clk) begin
    likelihood_t e;
    if (rst) begin
      gain_reg <= 32'h0001_0000;
      blen_reg <= 11'd32;
      bins_in_block = 0;
      l2_sum = 0;
      chi_sum = 0;
      total_dist = 0;
      sat_seen = 1'b0;
      likelihood_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (likelihood_q.size() == 0) begin
          report("unexpected item", 1, 0);
        end else begin
          e = likelihood_q.pop_front();
          if (weight !== e.weight) report("weight", weight, e.weight);
          if (score !== e.score) report("score", score, e.score);
          if (score_saturated !== e.saturated)
            report("score_saturated", score_saturated, e.saturated);
        end
      end
      if (in_valid && in_ready) fold_bin(measured_value, predicted_value, last_element);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_SCORE_GAIN) gain_reg <= pwdata;
        else blen_reg <= pwdata[10:0];
      end
    end
    // Results still owed to the receiver.
    pending = likelihood_q.size();
  end

endmodule

>>> bench/tb_histogram_l2_chi_square_likelihood_core.sv
// Top of the likelihood core testbench: clock, reset, register writes,
// bin stimulus in bursts and the receiver stall pattern.
// Depends on hcsl_pkg, the core and hcsl_likelihood_checker.
`timescale 1ns / 1ps

module tb_histogram_l2_chi_square_likelihood_core;
  import hcsl_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 150;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] measured_value;
  logic [15:0] predicted_value;
  logic        last_element;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] weight;
  logic [31:0] score;
  logic        score_saturated;
  int          errors;
  int          pending;
  int          bins_sent;
  int          cycles;
  int          burst_left;

  histogram_l2_chi_square_likelihood_core uut (.*);

  hcsl_likelihood_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_histogram_l2_chi_square_likelihood_core failed");
      $finish;
    end
  end

  // Receiver: one long hold-off once short particles are streaming, then random stalls.
  initial begin
    bit held;
    held = 0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!held && bins_sent >= 200) begin
        held = 1;
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 200)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(0, 15)) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Pause the sender until every likelihood is back and the core is idle.
  task automatic drain_and_configure(logic [31:0] gain, logic [10:0] blen);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_SCORE_GAIN, gain);
    write_reg(REG_BLOCK_LENGTH, {21'd0, blen});
  endtask

  // Offer one bin, holding it until it is taken; gaps fall between bursts.
  task automatic send_bin(logic [15:0] m, logic [15:0] p, logic last);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if ($urandom_range(0, 3) != 0) gap = int'($urandom_range(1, 40));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    measured_value <= m;
    predicted_value <= p;
    last_element <= last;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bins_sent++;
  endtask

  // A particle of random bins; narrow keeps values small so weights stay above zero.
  task automatic send_particle(int n, bit narrow, bit close);
    logic [15:0] m;
    logic [15:0] p;
    for (int i = 0; i < n; i++) begin
      m = narrow ? 16'($urandom_range(0, 300)) : 16'($urandom);
      p = narrow ? 16'($urandom_range(0, 300)) : 16'($urandom);
      if ($urandom_range(0, 15) == 0) p = m;
      send_bin(m, p, close && (i == n - 1));
    end
  endtask

  initial begin
    logic [31:0] g;
    logic [10:0] bl;
    cycles = 0;
    bins_sent = 0;
    burst_left = 0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'd0;
    pwdata <= 32'd0;
    in_valid <= 1'b0;
    measured_value <= 16'd0;
    predicted_value <= 16'd0;
    last_element <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero denominator, field extremes, one-bin particles.
    drain_and_configure(32'h0001_0000, 11'd2);
    send_bin(16'd0, 16'd0, 1'b0);
    send_bin(16'hFFFF, 16'd0, 1'b1);
    send_bin(16'd0, 16'hFFFF, 1'b0);
    send_bin(16'hFFFF, 16'hFFFF, 1'b0);
    send_bin(16'h5555, 16'hAAAA, 1'b1);
    send_bin(16'd0, 16'd0, 1'b1);
    drain_and_configure(32'h0000_0400, 11'd1);
    send_bin(16'd20, 16'd3, 1'b0);
    send_bin(16'd1, 16'd0, 1'b1);
    send_bin(16'd7, 16'd9, 1'b0);
    send_bin(16'd250, 16'd0, 1'b0);
    send_bin(16'd0, 16'd0, 1'b1);
    // Block length above range and zero, then the largest gain.
    drain_and_configure(32'h0000_0000, 11'd0);
    send_bin(16'd100, 16'd40, 1'b1);
    drain_and_configure(32'hFFFF_FFFF, 11'd2047);
    send_bin(16'd100, 16'd40, 1'b0);
    send_bin(16'hFFFF, 16'h0001, 1'b1);
    // Partial block left open: the next write shortens it mid-block.
    drain_and_configure(32'h0000_8000, 11'd3);
    send_bin(16'd30, 16'd10, 1'b0);
    send_bin(16'd31, 16'd11, 1'b0);
    drain_and_configure(32'h0000_8000, 11'd1);
    send_bin(16'd12, 16'd5, 1'b1);

    // Score saturation: one block of 64 maximal bins overflows the score.
    drain_and_configure(32'h0001_0000, 11'd64);
    for (int i = 0; i < 64; i++) send_bin(16'hFFFF, 16'd0, i == 63);

    // Random phases; particles may straddle a phase change.
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 4))
        0: g = 32'($urandom);
        1: g = 32'($urandom_range(0, 16));
        default: g = 32'($urandom_range(0, 32'h0003_0000));
      endcase
      bl = ($urandom_range(0, 5) == 0) ? 11'($urandom) : 11'($urandom_range(1, 6));
      drain_and_configure(g, bl);
      for (int k = 0; k < 10; k++)
        send_particle($urandom_range(1, 10), $urandom_range(0, 3) != 0,
                      (k != 9) || ($urandom_range(0, 1) == 0));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_histogram_l2_chi_square_likelihood_core passed");
    end else begin
      $display("tb_histogram_l2_chi_square_likelihood_core failed");
    end
    $finish;
  end

endmodule

>>> histogram_l2_chi_square_likelihood_core.f
+incdir+rtl
rtl/hcsl_pkg.sv
rtl/histogram_l2_chi_square_likelihood_core.sv
bench/hcsl_likelihood_checker.sv
bench/tb_histogram_l2_chi_square_likelihood_core.sv
